@@ rtl/http_request_head_validator_assert.svh @@
// Assertion helpers included by the top module of this block.
// Each use names clk and arst_n of the module that includes this file.
`ifndef HTTP_REQUEST_HEAD_VALIDATOR_ASSERT_SVH
`define HTTP_REQUEST_HEAD_VALIDATOR_ASSERT_SVH

// Same-cycle implication, masked while in reset
`define HRHV_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, masked while in reset
`define HRHV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/hrhv_pkg.sv @@
package hrhv_pkg;

	// Position inside the current line
	typedef enum logic [2:0] {
		PH_METHOD,
		PH_TARGET,
		PH_VERSION,
		PH_NAME,
		PH_VALUE
	} phase_t;

	// First fault seen in the head
	typedef enum logic [1:0] {
		FAULT_NONE,
		FAULT_MALFORMED,
		FAULT_TOO_MANY
	} fault_t;

	typedef enum logic [2:0] {
		VERDICT_OK,
		VERDICT_INCOMPLETE,
		VERDICT_MALFORMED,
		VERDICT_TOO_MANY,
		VERDICT_TOO_LARGE
	} verdict_t;

	// Configuration register indexes
	localparam logic CFG_HEADER_LIMIT = 1'b0;
	localparam logic CFG_BYTE_LIMIT   = 1'b1;

	localparam logic [7:0]  HEADER_LIMIT_RST = 8'd32;
	localparam logic [15:0] BYTE_LIMIT_RST   = 16'd8192;

	// Version field positions: "HTTP/" is 0..4, then d . d
	localparam logic [3:0] VPOS_MAJOR = 4'd5;
	localparam logic [3:0] VPOS_DOT   = 4'd6;
	localparam logic [3:0] VPOS_MINOR = 4'd7;
	localparam logic [3:0] VPOS_DONE  = 4'd8;

	localparam int M_TDATA_W = 40;
	localparam int RESULT_W  = 35;

	// Classified byte handed from the front to the back
	typedef struct packed {
		logic       is_cr;
		logic       is_lf;
		logic       is_sp;
		logic       is_ht;
		logic       is_colon;
		logic       tok_char;
		logic       is_visible;
		logic       is_digit;
		logic [3:0] digit;
		logic [4:0] ver_match;   // bit i set: byte equals "HTTP/"[i]
		logic       is_dot;
		logic       last;
	} byte_class_t;

	// Result beat, verdict in the lowest bits
	typedef struct packed {
		logic [3:0]  version_minor;
		logic [3:0]  version_major;
		logic [15:0] head_length;
		logic [7:0]  header_total;
		verdict_t    verdict;
	} result_t;

endpackage

@@ rtl/http_request_head_validator.sv @@
// Channel  Handshake               Payload
// cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
// s        s_tvalid / s_tready     s_tdata (request byte), s_tlast (final byte)
// m        m_tvalid / m_tready     m_tdata (verdict and head summary)
//
// One byte per cycle, except while a final byte waits on a stalled result beat; the parse
// state updates once per byte in the back. A final byte passes the classify stage, the
// queue and the result register before it is offered as its result beat.
// arst_n clears the valid flags, queue pointers and parse state; limits return to 32 headers and 8192 bytes.
// A stalled result beat holds only final bytes; bytes queued ahead of a final byte keep flowing.
// The queue between classifier and parser absorbs QUEUE_DEPTH beats.
module http_request_head_validator #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,    // 0 header_limit, 1 byte_limit
	input  logic [15:0] cfg_data,     // header_limit [7:0], byte_limit [15:0]
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,      // data_byte [7:0]
	input  logic        s_tlast,      // final_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata       // verdict [2:0], header_total [10:3],
	                                  // head_length [26:11], version_major [30:27],
	                                  // version_minor [34:31], zero [39:35]
);
	import hrhv_pkg::*;

	logic        front_valid;
	logic        front_ready;
	byte_class_t front_class;
	logic        head_valid;
	logic        head_ready;
	byte_class_t head_class;
	result_t     res_data;

	hrhv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.in_last   (s_tlast),
		.out_valid (front_valid),
		.out_ready (front_ready),
		.out_class (front_class)
	);

	hrhv_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_class  (front_class),
		.out_valid (head_valid),
		.out_ready (head_ready),
		.out_class (head_class)
	);

	hrhv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (head_valid),
		.in_ready  (head_ready),
		.in_class  (head_class),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res_data  (res_data)
	);

	assign m_tdata = {(M_TDATA_W - RESULT_W)'(0), res_data};

	`include "http_request_head_validator_assert.svh"

	// A final byte never overwrites a result still waiting
	`HRHV_ASSERT_NOW(a_no_result_overwrite, head_valid && head_ready && head_class.last, !m_tvalid || m_tready, "final byte taken while result beat stalled")
	// Every final byte parsed yields a result beat next cycle
	`HRHV_ASSERT_NEXT(a_final_gives_result, head_valid && head_ready && head_class.last, m_tvalid, "final byte parsed without result beat")
	// Input only stalls when the classify stage is occupied
	`HRHV_ASSERT_NOW(a_stall_has_cause, !s_tready, front_valid && !front_ready, "input stalled with free classify stage")

endmodule

@@ rtl/hrhv_front.sv @@
module hrhv_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           in_byte,
	input  logic                 in_last,
	output logic                 out_valid,
	input  logic                 out_ready,
	output hrhv_pkg::byte_class_t out_class
);
	import hrhv_pkg::*;

	logic        valid_s1;
	byte_class_t class_s1;

	function automatic byte_class_t classify(input logic [7:0] c, input logic lst);
		byte_class_t r;
		r.is_cr      = (c == 8'h0D);
		r.is_lf      = (c == 8'h0A);
		r.is_sp      = (c == 8'h20);
		r.is_ht      = (c == 8'h09);
		r.is_colon   = (c == 8'h3A);
		r.is_digit   = (c >= 8'h30) && (c <= 8'h39);
		r.is_visible = (c >= 8'h21) && (c <= 8'h7E);
		r.tok_char   = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
			|| r.is_digit
			|| (c == 8'h21) || (c == 8'h23) || (c == 8'h24) || (c == 8'h25)
			|| (c == 8'h26) || (c == 8'h27) || (c == 8'h2A) || (c == 8'h2B)
			|| (c == 8'h2D) || (c == 8'h2E) || (c == 8'h5E) || (c == 8'h5F)
			|| (c == 8'h60) || (c == 8'h7C) || (c == 8'h7E);
		r.digit      = c[3:0];
		r.ver_match  = {(c == 8'h2F), (c == 8'h50), (c == 8'h54), (c == 8'h54),
			(c == 8'h48)};
		r.is_dot     = (c == 8'h2E);
		r.last       = lst;
		return r;
	endfunction

	// One register stage; refills in the cycle it drains
	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			class_s1 <= classify(in_byte, in_last);
		end
	end

	assign out_valid = valid_s1;
	assign out_class = class_s1;

endmodule

@@ rtl/hrhv_queue.sv @@
module hrhv_queue #(
	parameter int DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  hrhv_pkg::byte_class_t in_class,
	output logic                  out_valid,
	input  logic                  out_ready,
	output hrhv_pkg::byte_class_t out_class
);
	import hrhv_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	byte_class_t       slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;
	logic              pop;

	assign in_ready  = (count_q != CNT_W'(DEPTH));
	assign out_valid = (count_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_class = slot_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_class;
		end
	end

endmodule

@@ rtl/hrhv_back.sv @@
module hrhv_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [15:0]           cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  hrhv_pkg::byte_class_t in_class,
	output logic                  res_valid,
	input  logic                  res_ready,
	output hrhv_pkg::result_t     res_data
);
	import hrhv_pkg::*;

	// Configuration
	logic [7:0]  header_limit_q;
	logic [15:0] byte_limit_q;

	// Parse state
	logic [16:0] tally_q, n_tally;
	phase_t      phase_q, n_phase;
	logic        held_cr_q, n_held_cr;
	logic        line_start_q, n_line_start;
	logic        term_q, n_term;
	logic [15:0] head_end_q, n_head_end;
	logic [7:0]  hdr_tally_q, n_hdr_tally;
	fault_t      fault_q, n_fault;
	logic        nonempty_q, n_nonempty;
	logic        line_bad_q, n_line_bad;
	logic [3:0]  vpos_q, n_vpos;
	logic [3:0]  major_q, n_major;
	logic [3:0]  minor_q, n_minor;

	verdict_t    verdict;
	result_t     result;
	logic        res_valid_q;
	result_t     res_q;
	logic        take;

	assign cfg_ready = 1'b1;

	// A final byte waits only for a free result slot
	assign in_ready = !in_class.last || !res_valid_q || res_ready;
	assign take     = in_valid && in_ready;

	// Next parse state for the byte at the queue head
	always_comb begin
		logic [16:0] idx;
		logic        done;
		idx          = tally_q;
		done         = 1'b0;
		n_tally      = tally_q;
		n_phase      = phase_q;
		n_held_cr    = held_cr_q;
		n_line_start = line_start_q;
		n_term       = term_q;
		n_head_end   = head_end_q;
		n_hdr_tally  = hdr_tally_q;
		n_fault      = fault_q;
		n_nonempty   = nonempty_q;
		n_line_bad   = line_bad_q;
		n_vpos       = vpos_q;
		n_major      = major_q;
		n_minor      = minor_q;

		// Saturates one past the limit
		if (tally_q <= {1'b0, byte_limit_q}) begin
			n_tally = tally_q + 17'd1;
		end

		if (!term_q) begin
			// CR from the previous byte
			if (held_cr_q) begin
				n_held_cr = 1'b0;
				if (in_class.is_lf) begin
					done = 1'b1;
					if (line_start_q && (phase_q >= PH_NAME)) begin
						n_term     = 1'b1;
						n_head_end = (idx >= 17'd3) ? 16'(idx - 17'd3) : 16'd0;
					end else begin
						// Close the line
						if (phase_q <= PH_VERSION) begin
							if (phase_q != PH_VERSION || vpos_q != VPOS_DONE) begin
								n_line_bad = 1'b1;
							end
							if (n_line_bad && fault_q == FAULT_NONE) begin
								n_fault = FAULT_MALFORMED;
							end
						end else begin
							if (phase_q == PH_NAME) begin
								n_line_bad = 1'b1;
							end
							if (n_line_bad) begin
								if (fault_q == FAULT_NONE) begin
									n_fault = FAULT_MALFORMED;
								end
							end else if (hdr_tally_q >= header_limit_q) begin
								if (fault_q == FAULT_NONE) begin
									n_fault = FAULT_TOO_MANY;
								end
							end else begin
								n_hdr_tally = hdr_tally_q + 8'd1;
							end
						end
						n_phase      = PH_NAME;
						n_nonempty   = 1'b0;
						n_line_bad   = 1'b0;
						n_line_start = 1'b1;
					end
				end else begin
					n_line_bad   = 1'b1;
					n_line_start = 1'b0;
				end
			end

			if (!done) begin
				if (in_class.is_cr) begin
					n_held_cr = 1'b1;
				end else if (in_class.is_lf) begin
					n_line_bad   = 1'b1;
					n_line_start = 1'b0;
				end else begin
					n_line_start = 1'b0;
					// Field content
					case (phase_q)
						PH_METHOD: begin
							if (in_class.is_sp) begin
								if (!nonempty_q) n_line_bad = 1'b1;
								n_phase    = PH_TARGET;
								n_nonempty = 1'b0;
							end else if (in_class.tok_char) begin
								n_nonempty = 1'b1;
							end else begin
								n_line_bad = 1'b1;
							end
						end
						PH_TARGET: begin
							if (in_class.is_sp) begin
								if (!nonempty_q) n_line_bad = 1'b1;
								n_phase = PH_VERSION;
								n_vpos  = '0;
							end else if (in_class.is_visible) begin
								n_nonempty = 1'b1;
							end else begin
								n_line_bad = 1'b1;
							end
						end
						PH_VERSION: begin
							if (vpos_q < VPOS_MAJOR) begin
								if (!in_class.ver_match[vpos_q[2:0]]) n_line_bad = 1'b1;
							end else if (vpos_q == VPOS_MAJOR) begin
								if (in_class.is_digit) n_major = in_class.digit;
								else n_line_bad = 1'b1;
							end else if (vpos_q == VPOS_DOT) begin
								if (!in_class.is_dot) n_line_bad = 1'b1;
							end else if (vpos_q == VPOS_MINOR) begin
								if (in_class.is_digit) n_minor = in_class.digit;
								else n_line_bad = 1'b1;
							end else begin
								n_line_bad = 1'b1;
							end
							if (vpos_q < VPOS_DONE) n_vpos = vpos_q + 4'd1;
						end
						PH_NAME: begin
							if (in_class.is_colon) begin
								if (!nonempty_q) n_line_bad = 1'b1;
								n_phase = PH_VALUE;
							end else if (in_class.tok_char) begin
								n_nonempty = 1'b1;
							end else begin
								n_line_bad = 1'b1;
							end
						end
						default: begin
							if (!(in_class.is_visible || in_class.is_sp || in_class.is_ht)) begin
								n_line_bad = 1'b1;
							end
						end
					endcase
				end
			end
		end
	end

	// Verdict from the state after this byte
	always_comb begin
		if (n_tally > {1'b0, byte_limit_q}) begin
			verdict = VERDICT_TOO_LARGE;
		end else if (!n_term) begin
			verdict = (n_tally == {1'b0, byte_limit_q}) ? VERDICT_TOO_LARGE
				: VERDICT_INCOMPLETE;
		end else if (n_fault == FAULT_MALFORMED) begin
			verdict = VERDICT_MALFORMED;
		end else if (n_fault == FAULT_TOO_MANY) begin
			verdict = VERDICT_TOO_MANY;
		end else begin
			verdict = VERDICT_OK;
		end
		result.verdict = verdict;
		if (verdict == VERDICT_OK) begin
			result.header_total  = n_hdr_tally;
			result.head_length   = n_head_end;
			result.version_major = n_major;
			result.version_minor = n_minor;
		end else begin
			result.header_total  = '0;
			result.head_length   = '0;
			result.version_major = '0;
			result.version_minor = '0;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_limit_q <= HEADER_LIMIT_RST;
			byte_limit_q   <= BYTE_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_HEADER_LIMIT: header_limit_q <= cfg_data[7:0];
				CFG_BYTE_LIMIT:   byte_limit_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Parse state; a final byte clears it for the next buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_q      <= '0;
			phase_q      <= PH_METHOD;
			held_cr_q    <= 1'b0;
			line_start_q <= 1'b1;
			term_q       <= 1'b0;
			head_end_q   <= '0;
			hdr_tally_q  <= '0;
			fault_q      <= FAULT_NONE;
			nonempty_q   <= 1'b0;
			line_bad_q   <= 1'b0;
			vpos_q       <= '0;
			major_q      <= '0;
			minor_q      <= '0;
		end else if (take) begin
			if (in_class.last) begin
				tally_q      <= '0;
				phase_q      <= PH_METHOD;
				held_cr_q    <= 1'b0;
				line_start_q <= 1'b1;
				term_q       <= 1'b0;
				head_end_q   <= '0;
				hdr_tally_q  <= '0;
				fault_q      <= FAULT_NONE;
				nonempty_q   <= 1'b0;
				line_bad_q   <= 1'b0;
				vpos_q       <= '0;
				major_q      <= '0;
				minor_q      <= '0;
			end else begin
				tally_q      <= n_tally;
				phase_q      <= n_phase;
				held_cr_q    <= n_held_cr;
				line_start_q <= n_line_start;
				term_q       <= n_term;
				head_end_q   <= n_head_end;
				hdr_tally_q  <= n_hdr_tally;
				fault_q      <= n_fault;
				nonempty_q   <= n_nonempty;
				line_bad_q   <= n_line_bad;
				vpos_q       <= n_vpos;
				major_q      <= n_major;
				minor_q      <= n_minor;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take && in_class.last) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_class.last) begin
			res_q <= result;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

@@ test/http_request_head_validator_tb.sv @@
`timescale 1ns / 1ps

module http_request_head_validator_tb;
	import hrhv_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int PHASE_BYTES    = 150;
	localparam int N_PHASES       = 8;
	localparam int N_DIRECTED     = 12;

	localparam logic [7:0] CR    = 8'h0D;
	localparam logic [7:0] LF    = 8'h0A;
	localparam logic [7:0] SP    = 8'h20;
	localparam logic [7:0] HT    = 8'h09;
	localparam logic [7:0] COLON = 8'h3A;
	localparam logic [7:0] DOT   = 8'h2E;

	// Byte classes for the request builder
	localparam int CLS_TOKEN  = 0;
	localparam int CLS_TARGET = 1;
	localparam int CLS_VALUE  = 2;
	localparam int CLS_ANY    = 3;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [15:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;      // data_byte [7:0]
	logic        s_tlast;      // final_byte
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;      // verdict [2:0], header_total [10:3], head_length [26:11],
	                           // version_major [30:27], version_minor [34:31], zero [39:35]

	http_request_head_validator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Limits as last written to the block
	logic [7:0]  hdr_limit_cfg;
	logic [15:0] byte_limit_cfg;

	// Parse state of the head checker
	logic [16:0] p_count;
	phase_t      p_phase;
	bit          p_cr_held;
	bit          p_line_start;
	bit          p_term;
	logic [15:0] p_head_at;
	logic [7:0]  p_hdr_count;
	fault_t      p_fault;
	bit          p_field_seen;
	bit          p_line_err;
	logic [3:0]  p_vpos;
	logic [3:0]  p_major;
	logic [3:0]  p_minor;

	string       http_tag = "HTTP/";
	result_t     pending_verdicts[$];
	logic [7:0]  req_bytes[$];
	int          mismatches = 0;
	int          bytes_sent = 0;
	int          src_idle_pct = 0;
	int          rx_stall_pct = 0;
	int          rx_hold_left = 0;
	int          quiet_cycles = 0;

	// Directed requests; a set check flag means the verdict below is the expectation
	int       dir_hlim [N_DIRECTED] = '{32, 32, 32, 32, 32, 32, 32, 0, 0, 255, 255, 255};
	int       dir_blim [N_DIRECTED] = '{8192, 8192, 8192, 8192, 8192, 8192, 8192, 8192, 8192,
		4, 4, 65535};
	bit       dir_chk [N_DIRECTED] = '{1, 1, 0, 1, 1, 1, 0, 1, 1, 1, 1, 0};
	verdict_t dir_vd [N_DIRECTED] = '{
		VERDICT_INCOMPLETE,  // lone high byte
		VERDICT_MALFORMED,   // empty request line, head at 0
		VERDICT_OK,
		VERDICT_MALFORMED,   // high byte inside a value
		VERDICT_MALFORMED,   // bare LF
		VERDICT_MALFORMED,   // bare CR
		VERDICT_OK,          // bytes past the terminator
		VERDICT_TOO_MANY,    // good header with a zero limit
		VERDICT_MALFORMED,   // bad header beyond the limit
		VERDICT_TOO_LARGE,   // no terminator, exactly at the byte limit
		VERDICT_TOO_LARGE,   // over the byte limit
		VERDICT_OK
	};
	string    dir_txt [N_DIRECTED] = '{
		"\377",
		"\015\012\015\012",
		"GET / HTTP/1.1\015\012\015\012",
		"A / HTTP/9.0\015\012B:\011x\200\015\012\015\012",
		"A / HTTP/1.0\012\015\012\015\012",
		"A / HTTP/1.0\015x\015\012\015\012",
		"A / HTTP/0.9\015\012H:v\015\012\015\012\377\015",
		"A / HTTP/1.1\015\012H:v\015\012\015\012",
		"A / HTTP/1.1\015\012:v\015\012\015\012",
		"abcd",
		"abcde",
		"~ * HTTP/1.1\015\012a:\011 \015\012\015\012"
	};

	// Per-phase limits and idling
	int phase_hdr [N_PHASES] = '{32, 0, 255, 2, 1, 3, 255, 2};
	int phase_byte [N_PHASES] = '{8192, 1, 65535, 40, 60, 30, 100, 8192};
	int idle_src [4] = '{0, 81, 0, 36};
	int idle_rx [4] = '{0, 0, 81, 36};

	function automatic bit is_num(input logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic bit is_vis(input logic [7:0] b);
		return b >= 8'h21 && b <= 8'h7E;
	endfunction

	function automatic bit tok_byte(input logic [7:0] b);
		case (b)
			"!", "#", "$", "%", "&", "'", "*", "+", "-", ".", "^", "_", 8'h60, "|", "~":
				return 1'b1;
			default:
				return is_num(b) || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
		endcase
	endfunction

	// Append one byte to the request being built
	function automatic void add_byte(input logic [7:0] b);
		req_bytes.insert(req_bytes.size(), b);
	endfunction

	function automatic void log_fault(input fault_t f);
		if (p_fault == FAULT_NONE)
			p_fault = f;
	endfunction

	function automatic void clear_parse();
		p_count      = '0;
		p_phase      = PH_METHOD;
		p_cr_held    = 1'b0;
		p_line_start = 1'b1;
		p_term       = 1'b0;
		p_head_at    = '0;
		p_hdr_count  = '0;
		p_fault      = FAULT_NONE;
		p_field_seen = 1'b0;
		p_line_err   = 1'b0;
		p_vpos       = '0;
		p_major      = '0;
		p_minor      = '0;
	endfunction

	// CR LF closing a line; a good header past the limit counts as too many
	function automatic void end_line();
		if (p_phase <= PH_VERSION ? (p_phase != PH_VERSION || p_vpos != VPOS_DONE)
				: p_phase == PH_NAME)
			p_line_err = 1'b1;
		if (p_line_err)
			log_fault(FAULT_MALFORMED);
		else if (p_phase >= PH_NAME) begin
			if (p_hdr_count >= hdr_limit_cfg)
				log_fault(FAULT_TOO_MANY);
			else
				p_hdr_count++;
		end
		p_phase      = PH_NAME;
		p_field_seen = 1'b0;
		p_line_err   = 1'b0;
		p_line_start = 1'b1;
	endfunction

	// One byte of line content
	function automatic void take_char(input logic [7:0] b);
		case (p_phase)
			PH_METHOD: begin
				if (b == SP) begin
					if (!p_field_seen)
						p_line_err = 1'b1;
					p_phase      = PH_TARGET;
					p_field_seen = 1'b0;
				end else if (tok_byte(b))
					p_field_seen = 1'b1;
				else
					p_line_err = 1'b1;
			end
			PH_TARGET: begin
				if (b == SP) begin
					if (!p_field_seen)
						p_line_err = 1'b1;
					p_phase = PH_VERSION;
					p_vpos  = '0;
				end else if (is_vis(b))
					p_field_seen = 1'b1;
				else
					p_line_err = 1'b1;
			end
			PH_VERSION: begin
				if (p_vpos < VPOS_MAJOR) begin
					if (b != http_tag[p_vpos])
						p_line_err = 1'b1;
				end else if (p_vpos == VPOS_MAJOR) begin
					if (is_num(b))
						p_major = b[3:0];
					else
						p_line_err = 1'b1;
				end else if (p_vpos == VPOS_DOT) begin
					if (b != DOT)
						p_line_err = 1'b1;
				end else if (p_vpos == VPOS_MINOR) begin
					if (is_num(b))
						p_minor = b[3:0];
					else
						p_line_err = 1'b1;
				end else
					p_line_err = 1'b1;
				if (p_vpos < VPOS_DONE)
					p_vpos++;
			end
			PH_NAME: begin
				if (b == COLON) begin
					if (!p_field_seen)
						p_line_err = 1'b1;
					p_phase = PH_VALUE;
				end else if (tok_byte(b))
					p_field_seen = 1'b1;
				else
					p_line_err = 1'b1;
			end
			default: begin
				if (!(is_vis(b) || b == SP || b == HT))
					p_line_err = 1'b1;
			end
		endcase
	endfunction

	// Head checker: advance by one byte, give the verdict beat on a final byte
	function automatic bit advance_parse(input logic [7:0] b, input logic last,
			output result_t res);
		logic [16:0] pos;
		bit          line_done;
		pos       = p_count;
		res       = '0;
		line_done = 1'b0;
		if (p_count <= byte_limit_cfg)
			p_count++;
		if (!p_term) begin
			if (p_cr_held) begin
				p_cr_held = 1'b0;
				if (b == LF) begin
					if (p_line_start && p_phase >= PH_NAME) begin
						p_term    = 1'b1;
						p_head_at = (pos >= 3) ? 16'(pos - 3) : 16'd0;
					end else
						end_line();
					line_done = 1'b1;
				end else begin
					p_line_err   = 1'b1;
					p_line_start = 1'b0;
				end
			end
			if (!line_done) begin
				if (b == CR)
					p_cr_held = 1'b1;
				else if (b == LF) begin
					p_line_err   = 1'b1;
					p_line_start = 1'b0;
				end else begin
					p_line_start = 1'b0;
					take_char(b);
				end
			end
		end
		if (!last)
			return 1'b0;

		if (p_count > byte_limit_cfg)
			res.verdict = VERDICT_TOO_LARGE;
		else if (!p_term)
			res.verdict = (p_count == byte_limit_cfg) ? VERDICT_TOO_LARGE : VERDICT_INCOMPLETE;
		else if (p_fault == FAULT_MALFORMED)
			res.verdict = VERDICT_MALFORMED;
		else if (p_fault == FAULT_TOO_MANY)
			res.verdict = VERDICT_TOO_MANY;
		else begin
			res.verdict       = VERDICT_OK;
			res.header_total  = p_hdr_count;
			res.head_length   = p_head_at;
			res.version_major = p_major;
			res.version_minor = p_minor;
		end
		clear_parse();
		return 1'b1;
	endfunction

	function automatic void add_chars(input int cls, input int n);
		logic [7:0] b;
		repeat (n) begin
			case (cls)
				CLS_TOKEN:
					do b = 8'($urandom_range(8'h21, 8'h7E)); while (!tok_byte(b));
				CLS_TARGET:
					b = 8'($urandom_range(8'h21, 8'h7E));
				CLS_VALUE: begin
					case ($urandom_range(9))
						0: b = HT;
						1: b = SP;
						default: b = 8'($urandom_range(8'h21, 8'h7E));
					endcase
				end
				default:
					b = 8'($urandom_range(255));
			endcase
			add_byte(b);
		end
	endfunction

	// Mostly well-formed requests with random content; some noise, damage or truncation
	function automatic void build_request();
		int shape;
		int pos;
		req_bytes.delete();
		shape = $urandom_range(99);
		if (shape < 8) begin
			add_chars(CLS_ANY, $urandom_range(1, 12));
			return;
		end
		add_chars(CLS_TOKEN, $urandom_range(1, 4));
		add_byte(SP);
		add_chars(CLS_TARGET, $urandom_range(1, 4));
		add_byte(SP);
		for (int i = 0; i < 5; i++)
			add_byte(http_tag[i]);
		add_byte(8'(8'h30 + $urandom_range(9)));
		add_byte(DOT);
		add_byte(8'(8'h30 + $urandom_range(9)));
		add_byte(CR);
		add_byte(LF);
		repeat (($urandom_range(7) == 0) ? $urandom_range(4, 9) : $urandom_range(0, 3)) begin
			add_chars(CLS_TOKEN, $urandom_range(1, 3));
			add_byte(COLON);
			add_chars(CLS_VALUE, $urandom_range(0, 4));
			add_byte(CR);
			add_byte(LF);
		end
		add_byte(CR);
		add_byte(LF);
		if ($urandom_range(9) == 0)
			add_chars(CLS_ANY, $urandom_range(1, 3));

		if (shape < 30) begin
			repeat ($urandom_range(1, 2)) begin
				pos = $urandom_range(req_bytes.size() - 1);
				case ($urandom_range(7))
					0: req_bytes[pos] = CR;
					1: req_bytes[pos] = LF;
					2: req_bytes[pos] = SP;
					3: req_bytes[pos] = COLON;
					4: req_bytes[pos] = 8'($urandom_range(8'h80, 8'hFF));
					5: req_bytes[pos] = 8'h00;
					6: req_bytes.delete(pos);
					default: req_bytes[pos] = 8'($urandom_range(255));
				endcase
			end
		end else if (shape < 38) begin
			repeat ($urandom_range(1, 4))
				req_bytes.pop_back();
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last,
			input bit typed = 1'b0, input verdict_t typed_verdict = VERDICT_OK);
		result_t res;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		bytes_sent++;
		if (advance_parse(b, last, res)) begin
			if (typed) begin
				res         = '0;
				res.verdict = typed_verdict;
			end
			pending_verdicts.insert(pending_verdicts.size(), res);
		end
	endtask

	// A request cut short leaves its parse open into the next phase
	task automatic send_request(input bit cut_short);
		int n;
		build_request();
		n = req_bytes.size();
		if (cut_short)
			n = $urandom_range(1, n);
		for (int i = 0; i < n; i++)
			send_byte(req_bytes[i], !cut_short && i == n - 1);
	endtask

	// Wait for every pending verdict, then let the pipeline run empty
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_limits(input logic [7:0] hl, input logic [15:0] bl);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= CFG_HEADER_LIMIT;
		cfg_data  <= {8'd0, hl};
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		hdr_limit_cfg = hl;
		cfg_index <= CFG_BYTE_LIMIT;
		cfg_data  <= bl;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		byte_limit_cfg = bl;
		cfg_valid <= 1'b0;
	endtask

	function automatic void check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			mismatches++;
		end
	endfunction

	// Result beats against the oldest pending verdict
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[RESULT_W-1:0];
			if (pending_verdicts.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, actual %h", $time, m_tdata);
				mismatches++;
			end else begin
				want = pending_verdicts.pop_front();
				check_field("verdict", want.verdict, got.verdict);
				check_field("header_total", want.header_total, got.header_total);
				check_field("head_length", want.head_length, got.head_length);
				check_field("version_major", want.version_major, got.version_major);
				check_field("version_minor", want.version_minor, got.version_minor);
				check_field("pad", 0, m_tdata[M_TDATA_W-1:RESULT_W]);
			end
		end
	end

	// Receiver: random stalls, or a long hold-off when requested
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				m_tready <= 1'b0;
			end else
				m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
			$display("http_request_head_validator regression: fail");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_HEADER_LIMIT;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		hdr_limit_cfg  = HEADER_LIMIT_RST;
		byte_limit_cfg = BYTE_LIMIT_RST;
		clear_parse();
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests
		for (int r = 0; r < N_DIRECTED; r++) begin
			if (dir_hlim[r] != hdr_limit_cfg || dir_blim[r] != byte_limit_cfg)
				write_limits(8'(dir_hlim[r]), 16'(dir_blim[r]));
			for (int i = 0; i < dir_txt[r].len(); i++)
				send_byte(dir_txt[r][i], i == dir_txt[r].len() - 1, dir_chk[r], dir_vd[r]);
		end

		// Random phases over limit settings and idling patterns
		for (int p = 0; p < N_PHASES; p++) begin
			int phase_start;
			write_limits(8'(phase_hdr[p]), 16'(phase_byte[p]));
			src_idle_pct = idle_src[p % 4];
			rx_stall_pct = idle_rx[p % 4];
			phase_start  = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES)
				send_request(1'b0);
			if ($urandom_range(1))
				send_request(1'b1);
		end

		// Long receiver hold-off while short requests keep coming
		write_limits(8'd4, 16'd12);
		src_idle_pct = 0;
		rx_stall_pct = 0;
		rx_hold_left = 300;
		repeat (24) begin
			repeat ($urandom_range(0, 2))
				send_byte(8'($urandom_range(255)), 1'b0);
			send_byte(8'($urandom_range(255)), 1'b1);
		end

		settle();
		if (mismatches == 0)
			$display("http_request_head_validator regression: pass");
		else
			$display("http_request_head_validator regression: fail");
		$finish;
	end

endmodule
